[rtl/lfsg_pkg.sv]
// ----------------------------------------------------------------------------
// lfsg_pkg: shared definitions of the line follow setpoint generator
// widths, scaling constants, register indexes and the structs between modules
// ----------------------------------------------------------------------------
package lfsg_pkg;

	// calibration length, kept a power of two so the averages are shifts
	localparam int CAL_LOG2    = 8;
	localparam int CAL_SAMPLES = 1 << CAL_LOG2;

	// fraction bits of the wheel angle accumulators
	localparam int FRAC_BITS = 12;

	// field widths
	localparam int IN_W     = 16;
	localparam int SET_W    = 19;
	localparam int ACC_W    = 31;
	localparam int SPEED_W  = 7;
	localparam int TARGET_W = 16;

	// derived widths of the calibration and steering arithmetic
	localparam int SUM_W  = IN_W + CAL_LOG2;
	localparam int DSUM_W = IN_W + 1 + CAL_LOG2;
	localparam int CNT_W  = CAL_LOG2 + 1;
	localparam int OFS_W  = IN_W + 1;
	localparam int DIFF_W = IN_W + 2;

	// scaling constants
	localparam int SPEED_MAX    = 100;
	localparam int SPEED_RESET  = 50;
	localparam int WHEEL_DIV    = 46;
	localparam int DIST_MUL     = 23;
	localparam int TARGET_SCALE = 100;
	localparam int WHITE_NUM    = 92;
	localparam int WHITE_DEN    = 100;
	localparam int DEADBAND     = 1000;

	// per-tick angle increment at full speed
	localparam int FULL_W = $clog2(((SPEED_MAX << FRAC_BITS) / WHEEL_DIV) + 1);
	localparam logic [FULL_W-1:0] FULL_RESET =
		FULL_W'((SPEED_RESET << FRAC_BITS) / WHEEL_DIV);

	localparam logic [ACC_W-1:0] ACC_MAX = '1;
	localparam logic [SET_W-1:0] SET_MAX = '1;

	// stream and configuration port widths
	localparam int IN_DATA_W  = 2 * IN_W;
	localparam int OUT_DATA_W = 2 * SET_W + 2;
	localparam int CAL_BIT    = 2 * SET_W;
	localparam int DONE_BIT   = 2 * SET_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED  = 2'd0,
		REG_TARGET = 2'd1,
		REG_STOP   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_CAL  = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef enum logic {
		STOP_DISTANCE = 1'b0,
		STOP_WHITE    = 1'b1
	} stop_mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [IN_W-1:0]  left;
		logic [IN_W-1:0]  right;
	} item_t;

	typedef struct packed {
		logic        [SUM_W-1:0]  sum_left;
		logic        [SUM_W-1:0]  sum_right;
		logic signed [DSUM_W-1:0] sum_diff;
		logic        [CNT_W-1:0]  count;
		logic signed [OFS_W-1:0]  offset;
		logic        [IN_W-1:0]   left_ref;
		logic        [IN_W-1:0]   right_ref;
	} cal_state_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc_left;
		logic [ACC_W-1:0] acc_right;
		logic             finished;
	} run_state_t;

	typedef struct packed {
		logic [FULL_W-1:0]   full_inc;
		logic [TARGET_W-1:0] target;
		stop_mode_t          stop_mode;
	} run_cfg_t;

	typedef struct packed {
		logic             done;
		logic             calibrated;
		logic [SET_W-1:0] right_sp;
		logic [SET_W-1:0] left_sp;
	} result_t;

endpackage

[rtl/lfsg_step.sv]
// ----------------------------------------------------------------------------
// lfsg_step: next state and result for one sensor pair
// calibration sums and averages, deadband steering, accumulators, stop tests
// ----------------------------------------------------------------------------
module lfsg_step import lfsg_pkg::*; (
	input  item_t      item,
	input  cal_state_t cal,
	input  run_state_t run,
	input  run_cfg_t   cfg,
	output cal_state_t cal_next,
	output run_state_t run_next,
	output result_t    res
);

	localparam int LHS_W = ACC_W + 6;
	localparam int RHS_W = TARGET_W + 7 + FRAC_BITS;
	localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int WHT_W = IN_W + 7;
	localparam logic signed [DIFF_W-1:0] DB_HI = DIFF_W'(DEADBAND);
	localparam logic signed [DIFF_W-1:0] DB_LO = -DB_HI;

	// travelled distance against the target, scaled to stay exact
	function automatic logic dist_hit(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b,
			logic [TARGET_W-1:0] target);
		logic [ACC_W:0]   total;
		logic [CMP_W-1:0] lhs;
		logic [CMP_W-1:0] rhs;
		total = {1'b0, a} + {1'b0, b};
		lhs   = CMP_W'(total) * CMP_W'(DIST_MUL);
		rhs   = (CMP_W'(target) * CMP_W'(TARGET_SCALE)) << FRAC_BITS;
		return lhs >= rhs;
	endfunction

	// saturating accumulator add
	function automatic logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] acc,
			logic [FULL_W-1:0] inc);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + (ACC_W+1)'(inc);
		return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	// accumulator to half degrees, saturating
	function automatic logic [SET_W-1:0] to_half(logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] h;
		h = acc >> (FRAC_BITS - 1);
		return (h > ACC_W'(SET_MAX)) ? SET_MAX : h[SET_W-1:0];
	endfunction

	logic                     cal_done;
	logic        [SUM_W-1:0]  sum_l_new;
	logic        [SUM_W-1:0]  sum_r_new;
	logic signed [DSUM_W-1:0] sum_d_new;
	logic signed [DSUM_W-1:0] sum_d_bias;
	logic        [CNT_W-1:0]  cnt_new;
	logic signed [DIFF_W-1:0] diff;
	logic [FULL_W-1:0]        inc_l;
	logic [FULL_W-1:0]        inc_r;
	logic [ACC_W-1:0]         acc_l_new;
	logic [ACC_W-1:0]         acc_r_new;
	logic                     pre_hit;
	logic                     post_hit;
	logic                     white;

	// calibration sums, including the current sample
	assign cal_done  = cal.count >= CNT_W'(CAL_SAMPLES);
	assign sum_l_new = cal.sum_left + SUM_W'(item.left);
	assign sum_r_new = cal.sum_right + SUM_W'(item.right);
	assign sum_d_new = cal.sum_diff + DSUM_W'($signed({1'b0, item.left}))
		- DSUM_W'($signed({1'b0, item.right}));
	assign cnt_new   = cal.count + CNT_W'(1);

	// bias a negative sum so the shift rounds toward zero
	assign sum_d_bias = sum_d_new[DSUM_W-1] ?
		sum_d_new + DSUM_W'(CAL_SAMPLES - 1) : sum_d_new;

	// offset corrected difference and deadband steering
	assign diff = DIFF_W'($signed({1'b0, item.left}))
		- DIFF_W'($signed({1'b0, item.right})) - DIFF_W'(cal.offset);
	assign inc_l = (diff > DB_HI) ? '0 : cfg.full_inc;
	assign inc_r = (diff < DB_LO) ? '0 : cfg.full_inc;

	assign acc_l_new = acc_add(run.acc_left, inc_l);
	assign acc_r_new = acc_add(run.acc_right, inc_r);

	// stop tests before and after motion
	assign pre_hit  = dist_hit(run.acc_left, run.acc_right, cfg.target);
	assign post_hit = dist_hit(acc_l_new, acc_r_new, cfg.target);
	assign white = (WHT_W'(item.left) * WHT_W'(WHITE_DEN)
			< WHT_W'(cal.left_ref) * WHT_W'(WHITE_NUM))
		&& (WHT_W'(item.right) * WHT_W'(WHITE_DEN)
			< WHT_W'(cal.right_ref) * WHT_W'(WHITE_NUM));

	// calibration state update
	always_comb begin
		cal_next = cal;
		if (item.mode == MODE_CAL && !cal_done) begin
			cal_next.sum_left  = sum_l_new;
			cal_next.sum_right = sum_r_new;
			cal_next.sum_diff  = sum_d_new;
			cal_next.count     = cnt_new;
			if (cnt_new == CNT_W'(CAL_SAMPLES)) begin
				cal_next.left_ref  = sum_l_new[SUM_W-1:CAL_LOG2];
				cal_next.right_ref = sum_r_new[SUM_W-1:CAL_LOG2];
				cal_next.offset    = OFS_W'(sum_d_bias >>> CAL_LOG2);
			end
		end
	end

	// run state update on a control tick
	always_comb begin
		run_next = run;
		if (item.mode == MODE_TICK && !run.finished) begin
			if (cfg.stop_mode == STOP_DISTANCE && pre_hit) begin
				run_next.finished = 1'b1;
			end else begin
				run_next.acc_left  = acc_l_new;
				run_next.acc_right = acc_r_new;
				run_next.finished  = (cfg.stop_mode == STOP_DISTANCE) ? post_hit : white;
			end
		end
	end

	// result from the updated state
	assign res.left_sp    = to_half(run_next.acc_left);
	assign res.right_sp   = to_half(run_next.acc_right);
	assign res.calibrated = cal_next.count >= CNT_W'(CAL_SAMPLES);
	assign res.done       = run_next.finished;

endmodule

[rtl/line_follow_setpoint_generator.sv]
// ----------------------------------------------------------------------------
// line_follow_setpoint_generator: wheel setpoints for a differential line
// follower with reference calibration and bang-bang steering
// ----------------------------------------------------------------------------
// One sensor pair is accepted every cycle while the output is not stalled, and
// each gives one result: the pair is captured in an input register, the whole
// step (sums, steering, accumulator update and stop tests) runs in one pass of
// logic, and the result waits in an output register, so a stalled output holds
// at most one pair in flight before the input side stalls too. The first
// CAL_SAMPLES pairs with tuser low build the reference levels; pairs with tuser
// high are control ticks. Registers are to be written through the cfg channel
// only while the stream is idle, which the block itself does not enforce; every
// write to a defined register restarts the run. Reset needs no clearing pass.
module line_follow_setpoint_generator import lfsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: left_intensity[15:0], right_intensity[31:16]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: mode[0]
	input  logic                  s_tuser,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// m_tdata: left_setpoint[18:0], right_setpoint[37:19], calibrated[38],
	// done_res[39]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [FULL_W-1:0]  full_tab [SPEED_MAX+1];
	logic [SPEED_W-1:0] speed_sat;
	logic               cfg_hit;

	run_cfg_t   cfg_q;
	cal_state_t cal_q;
	run_state_t run_q;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	logic       adv;

	cal_state_t cal_next;
	run_state_t run_next;
	result_t    res_next;

	// increment per tick for each speed
	for (genvar i = 0; i <= SPEED_MAX; i++) begin : g_full
		assign full_tab[i] = FULL_W'((i << FRAC_BITS) / WHEEL_DIV);
	end

	assign speed_sat = (cfg_data[SPEED_W-1:0] > SPEED_W'(SPEED_MAX)) ?
		SPEED_W'(SPEED_MAX) : cfg_data[SPEED_W-1:0];

	// configuration writes
	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			REG_SPEED, REG_TARGET, REG_STOP: cfg_hit = cfg_valid;
			default:                         cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_inc  <= FULL_RESET;
			cfg_q.target    <= '0;
			cfg_q.stop_mode <= STOP_DISTANCE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED:  cfg_q.full_inc  <= full_tab[speed_sat];
				REG_TARGET: cfg_q.target    <= cfg_data[TARGET_W-1:0];
				REG_STOP:   cfg_q.stop_mode <= stop_mode_t'(cfg_data[0]);
				default:    cfg_q           <= cfg_q;
			endcase
		end
	end

	// pipeline control
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode  <= mode_t'(s_tuser);
			item_s1.left  <= s_tdata[IN_W-1:0];
			item_s1.right <= s_tdata[IN_DATA_W-1:IN_W];
		end
	end

	// one step of the controller
	lfsg_step u_step (
		.item     (item_s1),
		.cal      (cal_q),
		.run      (run_q),
		.cfg      (cfg_q),
		.cal_next (cal_next),
		.run_next (run_next),
		.res      (res_next)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
			run_q <= '0;
		end else begin
			if (adv) begin
				cal_q <= cal_next;
			end
			priority if (cfg_hit) begin
				run_q <= '0;
			end else if (adv) begin
				run_q <= run_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

endmodule

[rtl/lfsg_checker.sv]
// ----------------------------------------------------------------------------
// lfsg_checker: port level checks of the line follow setpoint generator
// bound to the top level, reports through $error
// ----------------------------------------------------------------------------
module lfsg_checker import lfsg_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready
);

	logic cal_seen_q;

	// remember that a calibrated result has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[CAL_BIT]) begin
			cal_seen_q <= 1'b1;
		end
	end

	// no result shows while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// an empty output register never blocks the input
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// calibration never comes undone
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cal_seen_q |-> m_tdata[CAL_BIT])
		else $error("calibrated flag dropped");

endmodule

bind line_follow_setpoint_generator lfsg_checker u_lfsg_checker (.*);

[tb/sv/line_follow_setpoint_generator_test.sv]
// ----------------------------------------------------------------------------
// line_follow_setpoint_generator_test: self-checking stream testbench
// Sensor pairs and register writes are queued up front, a clocked driver
// feeds them with random gaps, and a clocked monitor predicts every result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module line_follow_setpoint_generator_test;
	import lfsg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAP_MAX       = 19;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLD_CYCLES   = 100;
	localparam int QUIET_LIMIT   = 2000;
	localparam int REPORT_MAX    = 10;
	localparam int ITEM_TARGET   = 900;
	localparam int STEER_DIV     = 100;
	localparam int HOLD_PHASE    = 6;
	localparam int PAUSE_PHASE   = 3;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_WRITE,
		OP_PAUSE,
		OP_HOLD
	} plan_kind_t;

	typedef struct {
		plan_kind_t            kind;
		item_t                 item;
		logic                  burst;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} plan_op_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expected results
	plan_op_t plan_q[$];
	result_t  setpoint_q[$];
	int       pending = 0;
	int       fault_count = 0;

	// driver, receiver hold-off and watchdog bookkeeping
	int   feed_gap = 0;
	int   feed_settle = 0;
	logic feed_burst = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	wire  sink_hold = hold_left != 0;
	int   rx_wait = 0;
	int   rx_count = 0;
	logic rx_calm = 1'b0;
	int   quiet_cycles = 0;

	// predicted register and run state
	logic        [SPEED_W-1:0]  set_speed;
	logic        [TARGET_W-1:0] set_target;
	stop_mode_t                 set_stop;
	logic        [SUM_W-1:0]    cal_sum_l;
	logic        [SUM_W-1:0]    cal_sum_r;
	logic signed [DSUM_W-1:0]   cal_sum_d;
	logic        [CNT_W-1:0]    cal_count;
	logic signed [OFS_W-1:0]    cal_offset;
	logic        [IN_W-1:0]     ref_left;
	logic        [IN_W-1:0]     ref_right;
	logic        [ACC_W-1:0]    angle_left;
	logic        [ACC_W-1:0]    angle_right;
	logic                       run_done;

	line_follow_setpoint_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// stimulus planning
	function automatic void plan_item(mode_t mode, int left, int right, logic burst);
		plan_op_t op;
		op.kind = OP_ITEM;
		op.item.mode = mode;
		op.item.left = IN_W'(left);
		op.item.right = IN_W'(right);
		op.burst = burst;
		op.index = '0;
		op.data = '0;
		plan_q.push_back(op);
	endfunction

	function automatic void plan_write(logic [CFG_IDX_W-1:0] index, int data);
		plan_op_t op;
		op.kind = OP_WRITE;
		op.item = '0;
		op.burst = 1'b0;
		op.index = index;
		op.data = CFG_DATA_W'(data);
		plan_q.push_back(op);
	endfunction

	function automatic void plan_marker(plan_kind_t kind);
		plan_op_t op;
		op.kind = kind;
		op.item = '0;
		op.burst = 1'b0;
		op.index = '0;
		op.data = '0;
		plan_q.push_back(op);
	endfunction

	// control tick aimed at the interesting regions around the references
	function automatic item_t steer_tick();
		item_t it;
		int base;
		it.mode = MODE_TICK;
		case ($urandom_range(0, 6))
			0, 1, 2: begin
				// near the line: difference straddles the deadband
				base = int'($urandom_range(36000, 46000));
				it.right = IN_W'(base);
				it.left = IN_W'(base + int'($urandom_range(0, 3000)) - 1500);
			end
			3: begin
				// both sensors on white
				it.left = IN_W'($urandom_range(0, 36000));
				it.right = IN_W'($urandom_range(0, 36000));
			end
			4: begin
				// around the white threshold
				it.left = IN_W'($urandom_range(33000, 41000));
				it.right = IN_W'($urandom_range(33000, 41000));
			end
			default: begin
				it.left = IN_W'($urandom);
				it.right = IN_W'($urandom);
			end
		endcase
		return it;
	endfunction

	// prediction
	function automatic logic [ACC_W-1:0] bump_angle(logic [ACC_W-1:0] acc,
			logic [ACC_W-1:0] inc);
		logic [ACC_W:0] sum;
		sum = {1'b0, acc} + {1'b0, inc};
		return (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
	endfunction

	function automatic logic [SET_W-1:0] half_degrees(logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] h;
		h = acc >> (FRAC_BITS - 1);
		return (h > ACC_W'(SET_MAX)) ? SET_MAX : h[SET_W-1:0];
	endfunction

	function automatic logic reached_distance();
		logic [63:0] travel;
		logic [63:0] goal;
		travel = (64'(angle_left) + 64'(angle_right)) * 64'(DIST_MUL);
		goal = (64'(set_target) * 64'(TARGET_SCALE)) << FRAC_BITS;
		return travel >= goal;
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] index,
			logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_SPEED: set_speed = (data[SPEED_W-1:0] > SPEED_MAX) ?
				SPEED_W'(SPEED_MAX) : data[SPEED_W-1:0];
			REG_TARGET: set_target = data;
			REG_STOP: set_stop = stop_mode_t'(data[0]);
			default: return;
		endcase
		angle_left = '0;
		angle_right = '0;
		run_done = 1'b0;
	endfunction

	function automatic result_t advance_setpoints(item_t it);
		result_t res;
		logic cal_done;
		logic [ACC_W-1:0] full, inc_l, inc_r;
		longint diff, delta;
		cal_done = cal_count >= CAL_SAMPLES;
		if (it.mode == MODE_CAL) begin
			// calibration sums, ignored once the references are set
			if (!cal_done) begin
				cal_sum_l = cal_sum_l + it.left;
				cal_sum_r = cal_sum_r + it.right;
				cal_sum_d = DSUM_W'(longint'(cal_sum_d) + longint'(it.left) -
					longint'(it.right));
				cal_count = cal_count + 1'b1;
				if (cal_count >= CAL_SAMPLES) begin
					ref_left = IN_W'(cal_sum_l / CAL_SAMPLES);
					ref_right = IN_W'(cal_sum_r / CAL_SAMPLES);
					cal_offset = OFS_W'(longint'(cal_sum_d) / CAL_SAMPLES);
					cal_done = 1'b1;
				end
			end
		end else if (!run_done) begin
			if (set_stop == STOP_DISTANCE && reached_distance()) begin
				run_done = 1'b1;
			end else begin
				// bang-bang steering outside the deadband
				full = ACC_W'((int'(set_speed) << FRAC_BITS) / WHEEL_DIV);
				diff = longint'(it.left) - longint'(it.right) - longint'(cal_offset);
				delta = diff / STEER_DIV;
				inc_l = full;
				inc_r = full;
				if (diff > DEADBAND || diff < -DEADBAND) begin
					if (1 - delta <= 0)
						inc_l = '0;
					if (1 + delta <= 0)
						inc_r = '0;
				end
				angle_left = bump_angle(angle_left, inc_l);
				angle_right = bump_angle(angle_right, inc_r);
				// stop test after the move
				if (set_stop == STOP_DISTANCE) begin
					if (reached_distance())
						run_done = 1'b1;
				end else if (longint'(it.left) * WHITE_DEN < longint'(ref_left) * WHITE_NUM &&
						longint'(it.right) * WHITE_DEN < longint'(ref_right) * WHITE_NUM) begin
					run_done = 1'b1;
				end
			end
		end
		res.left_sp = half_degrees(angle_left);
		res.right_sp = half_degrees(angle_right);
		res.calibrated = cal_done;
		res.done = run_done;
		return res;
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// driver: feeds sensor pairs and register writes from the plan
	always @(posedge clk or negedge arst_n) begin : feed
		plan_op_t head;
		logic busy_item, busy_cfg, offer_item, offer_cfg, hold_pulse;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			hold_req <= 1'b0;
			feed_gap = 0;
			feed_settle = 0;
		end else begin
			hold_pulse = 1'b0;
			offer_item = 1'b0;
			offer_cfg = 1'b0;
			busy_item = s_tvalid && !s_tready;
			busy_cfg = cfg_valid && !cfg_ready;
			if (s_tvalid && s_tready && !feed_burst)
				feed_gap = $urandom_range(0, GAP_MAX);
			// count quiet cycles before a register write or a pause ends
			if (pending == 0 && !m_tvalid && !s_tvalid && !cfg_valid)
				feed_settle++;
			else
				feed_settle = 0;
			if (busy_item || busy_cfg) begin
				// transaction still waiting
			end else if (feed_gap > 0) begin
				feed_gap--;
			end else if (plan_q.size() != 0) begin
				head = plan_q[0];
				case (head.kind)
					OP_ITEM: begin
						plan_q.delete(0);
						offer_item = 1'b1;
						feed_burst = head.burst;
						s_tdata <= {head.item.right, head.item.left};
						s_tuser <= head.item.mode;
					end
					OP_WRITE: if (feed_settle >= SETTLE_CYCLES) begin
						plan_q.delete(0);
						offer_cfg = 1'b1;
						cfg_index <= head.index;
						cfg_data <= head.data;
					end
					OP_PAUSE: if (feed_settle >= SETTLE_CYCLES) begin
						plan_q.delete(0);
					end
					default: begin
						plan_q.delete(0);
						hold_pulse = 1'b1;
					end
				endcase
			end
			s_tvalid <= busy_item || offer_item;
			cfg_valid <= busy_cfg || offer_cfg;
			hold_req <= hold_pulse;
		end
	end

	// long receiver hold-off so the block fills up and stalls its input
	always @(posedge clk or negedge arst_n) begin : backpressure
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: predicts on every accepted pair and checks every result
	always @(posedge clk or negedge arst_n) begin : observe
		result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			pending <= 0;
			setpoint_q.delete();
			set_speed = SPEED_W'(SPEED_RESET);
			set_target = '0;
			set_stop = STOP_DISTANCE;
			cal_sum_l = '0;
			cal_sum_r = '0;
			cal_sum_d = '0;
			cal_count = '0;
			cal_offset = '0;
			ref_left = '0;
			ref_right = '0;
			angle_left = '0;
			angle_right = '0;
			run_done = 1'b0;
			rx_wait = 0;
		end else begin
			// result transaction
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (setpoint_q.size() == 0) begin
					note_fault($sformatf("result with nothing expected: %h", m_tdata));
				end else begin
					want = setpoint_q.pop_front();
					if (got.left_sp !== want.left_sp)
						note_fault($sformatf("left_setpoint expected %0d got %0d",
							want.left_sp, got.left_sp));
					if (got.right_sp !== want.right_sp)
						note_fault($sformatf("right_setpoint expected %0d got %0d",
							want.right_sp, got.right_sp));
					if (got.calibrated !== want.calibrated)
						note_fault($sformatf("calibrated expected %0b got %0b",
							want.calibrated, got.calibrated));
					if (got.done !== want.done)
						note_fault($sformatf("done_res expected %0b got %0b",
							want.done, got.done));
				end
				rx_count++;
				if (rx_count % 64 == 0)
					rx_calm = $urandom_range(0, 3) == 0;
				rx_wait = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= rx_wait == 0 && !sink_hold;
			// register transaction
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			// sensor pair transaction
			if (s_tvalid && s_tready)
				setpoint_q.push_back(advance_setpoints({mode_t'(s_tuser),
					s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]}));
			pending <= setpoint_q.size();
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("line_follow_setpoint_generator_test: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int n_items, n_cal, batch, phase, wdata;
		logic burst;
		item_t it;

		// defaults: zero target finishes without motion, then the hold
		plan_item(MODE_TICK, 0, 0, 1'b0);
		plan_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 1'b0);
		// white stop before calibration never fires; steering extremes
		plan_write(REG_TARGET, 16'hFFFF);
		plan_write(REG_STOP, STOP_WHITE);
		plan_item(MODE_TICK, 16'hFFFF, 0, 1'b0);
		plan_item(MODE_TICK, 0, 16'hFFFF, 1'b0);
		plan_item(MODE_TICK, DEADBAND, 0, 1'b0);
		plan_item(MODE_TICK, 0, DEADBAND, 1'b0);
		plan_item(MODE_TICK, DEADBAND + 1, 0, 1'b0);
		plan_item(MODE_TICK, 0, DEADBAND + 1, 1'b0);
		plan_item(MODE_TICK, 0, 0, 1'b0);
		// zero speed, saturating speed writes, spare index
		plan_write(REG_SPEED, 0);
		plan_item(MODE_TICK, 20000, 20000, 1'b0);
		plan_write(REG_SPEED, 16'h007F);
		plan_item(MODE_TICK, 12345, 54321, 1'b0);
		plan_write(REG_SPARE, 16'hFFFF);
		plan_item(MODE_TICK, 1, 1, 1'b0);
		plan_write(REG_SPEED, SPEED_MAX + 1);
		plan_item(MODE_TICK, 30000, 30000, 1'b0);
		plan_write(REG_SPEED, 16'hFF80);
		plan_item(MODE_TICK, 40000, 40000, 1'b0);
		// short distance run at full speed
		plan_write(REG_SPEED, SPEED_MAX);
		plan_write(REG_STOP, STOP_DISTANCE);
		plan_write(REG_TARGET, 2);
		repeat (5)
			plan_item(MODE_TICK, 34000, 34000, 1'b0);
		n_items = 19;

		// calibration with ticks mixed in
		plan_write(REG_TARGET, 16'hFFFF);
		plan_write(REG_SPEED, 60);
		plan_item(MODE_CAL, 16'hFFFF, 0, 1'b0);
		plan_item(MODE_CAL, 0, 16'hFFFF, 1'b0);
		n_cal = 2;
		while (n_cal < CAL_SAMPLES) begin
			if ($urandom_range(0, 7) == 0) begin
				plan_item(MODE_TICK, $urandom, $urandom, 1'b0);
			end else begin
				plan_item(MODE_CAL, $urandom_range(36000, 46000),
					$urandom_range(36000, 46000), 1'b0);
				n_cal++;
			end
			n_items++;
		end
		n_items += 2;

		// random runs, each started by register writes
		phase = 0;
		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 4))
				0: wdata = 0;
				1: wdata = SPEED_MAX;
				2: wdata = 16'h007F;
				3: wdata = int'($urandom);
				default: wdata = int'($urandom_range(1, SPEED_MAX));
			endcase
			if ($urandom_range(0, 1))
				plan_write(REG_SPEED, wdata);
			case ($urandom_range(0, 5))
				0: wdata = 0;
				1: wdata = 16'hFFFF;
				2: wdata = int'($urandom);
				default: wdata = int'($urandom_range(1, 60));
			endcase
			plan_write(REG_TARGET, wdata);
			if ($urandom_range(0, 1))
				plan_write(REG_STOP, int'($urandom));
			if ($urandom_range(0, 15) == 0)
				plan_write(REG_SPARE, int'($urandom));
			burst = phase == HOLD_PHASE || $urandom_range(0, 3) == 0;
			if (phase == HOLD_PHASE)
				plan_marker(OP_HOLD);
			batch = $urandom_range(15, 50);
			for (int i = 0; i < batch; i++) begin
				if (i == batch / 2 && (phase == PAUSE_PHASE || $urandom_range(0, 3) == 0))
					plan_marker(OP_PAUSE);
				if ($urandom_range(0, 15) == 0) begin
					// late calibration sample, ignored by the block
					plan_item(MODE_CAL, $urandom, $urandom, burst);
				end else begin
					it = steer_tick();
					plan_item(it.mode, it.left, it.right, burst);
					n_items++;
				end
			end
			phase++;
		end

		// reset and run
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (plan_q.size() != 0 || s_tvalid || cfg_valid || setpoint_q.size() != 0 ||
			m_tvalid);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (setpoint_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", setpoint_q.size()));
		if (fault_count == 0)
			$display("line_follow_setpoint_generator_test: clean");
		else
			$display("line_follow_setpoint_generator_test: errors");
		$finish;
	end

endmodule
